FILE: design/tgm_pkg.sv
// ----------------------------------------------------------------------------
// tgm_pkg
// Types, codes and constants shared by the touch to gamepad mapper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tgm_pkg;

	localparam int DEFAULT_SLOTS = 2;

	localparam int CFG_W   = 12;
	localparam int CFG_IDX_W = 3;
	localparam int VAL_W   = 32;
	localparam int ALU_W   = 35;
	localparam int DIFF_W  = 33;

	localparam logic [4:0] EV_TYPE_SYNC = 5'd0;
	localparam logic [4:0] EV_TYPE_ABS  = 5'd3;

	localparam logic [9:0] CODE_SLOT   = 10'h02f;
	localparam logic [9:0] CODE_TRACK  = 10'h039;
	localparam logic [9:0] CODE_POS_X  = 10'h035;
	localparam logic [9:0] CODE_POS_Y  = 10'h036;
	localparam logic [9:0] CODE_REPORT = 10'h000;

	localparam logic [VAL_W-1:0] TRACK_END = 32'hFFFF_FFFF;

	localparam logic [CFG_IDX_W-1:0] CFG_MOVE_THRESHOLD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROCKER_ZONE_X  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM_ROW_Y   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TOP_ROW_Y      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_SPLIT_X = 3'd4;

	localparam logic [CFG_W-1:0] RST_MOVE_THRESHOLD = 12'd20;
	localparam logic [CFG_W-1:0] RST_ROCKER_ZONE_X  = 12'd240;
	localparam logic [CFG_W-1:0] RST_BOTTOM_ROW_Y   = 12'd400;
	localparam logic [CFG_W-1:0] RST_TOP_ROW_Y      = 12'd200;
	localparam logic [CFG_W-1:0] RST_COLUMN_SPLIT_X = 12'd380;

	localparam int BTN_A      = 0;
	localparam int BTN_B      = 1;
	localparam int BTN_SELECT = 2;
	localparam int BTN_START  = 3;
	localparam int BTN_UP     = 4;
	localparam int BTN_DOWN   = 5;
	localparam int BTN_LEFT   = 6;
	localparam int BTN_RIGHT  = 7;

	typedef enum logic [1:0] {
		ROLE_UNASSIGNED = 2'd0,
		ROLE_JOYSTICK   = 2'd1,
		ROLE_BUTTON     = 2'd2
	} role_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ROLE,
		ST_DX,
		ST_DXP,
		ST_DXN,
		ST_DY,
		ST_DYP,
		ST_DYN,
		ST_BX,
		ST_BBOT,
		ST_BTOP,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [ALU_W-1:0] diff;
		logic             neg;
		logic             pos;
	} alu_res_t;

endpackage

FILE: design/tgm_if.sv
// ----------------------------------------------------------------------------
// tgm_event_if / tgm_buttons_if
// Valid/ready channels for touch event items and button mask items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tgm_event_if;
	logic              valid;
	logic              ready;
	logic [4:0]        event_type;
	logic [9:0]        event_code;
	logic signed [31:0] event_value;

	modport source (output valid, output event_type, output event_code,
		output event_value, input ready);
	modport sink (input valid, input event_type, input event_code,
		input event_value, output ready);
endinterface

interface tgm_buttons_if;
	logic       valid;
	logic       ready;
	logic [7:0] buttons;

	modport source (output valid, output buttons, input ready);
	modport sink (input valid, input buttons, output ready);
endinterface

FILE: design/tgm_sub_unit.sv
// ----------------------------------------------------------------------------
// tgm_sub_unit
// Shared signed subtract and sign compare used by the sequencer's compare steps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tgm_sub_unit
	import tgm_pkg::*;
(
	input  logic signed [ALU_W-1:0] a,
	input  logic signed [ALU_W-1:0] b,
	output alu_res_t                res
);

	logic signed [ALU_W-1:0] diff;

	assign diff     = a - b;
	assign res.diff = diff;
	assign res.neg  = diff[ALU_W-1];
	assign res.pos  = !diff[ALU_W-1] && (diff != '0);

endmodule

FILE: design/touch_to_gamepad_mapper_core.sv
// ----------------------------------------------------------------------------
// touch_to_gamepad_mapper_core
// Maps multi-touch event items to an 8-bit gamepad button mask.
// ----------------------------------------------------------------------------
// Channels: ev (sink) takes one event item per handshake; btn (source) gives
// a button mask item whenever a sync report yields a mask unlike the last one
// sent. Registers are written through cfg_we / cfg_index / cfg_wdata; the user
// must write them only while idle, the block itself does not enforce it. A sync
// report walks the slots: an inactive slot has only the role step, a button
// contact adds column, bottom-row and (unless below it) top-row compares, a
// joystick contact x/y delta and threshold compares; a done step ends the walk.
// The single shared subtractor does one signed compare per cycle in the walk.
// ev.ready is high only while the sequencer is idle. The result sits in an
// output register, so new items are taken while it waits; a report whose new
// mask finds that register still full holds in its last step until btn.ready.
// Reset (arst_n low) clears all slots, the slot pointer, the last mask and
// restores the register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module touch_to_gamepad_mapper_core
	import tgm_pkg::*;
#(
	parameter int SLOTS = DEFAULT_SLOTS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	tgm_event_if.sink            ev,
	tgm_buttons_if.source        btn,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	logic [CFG_W-1:0] thr_q, rocker_q, bottom_q, top_q, column_q;

	logic [SW-1:0]    sel_slot_q;
	logic             active_q [SLOTS];
	role_t            role_q   [SLOTS];
	logic [VAL_W-1:0] x_q      [SLOTS];
	logic [VAL_W-1:0] y_q      [SLOTS];
	logic [VAL_W-1:0] ax_q     [SLOTS];
	logic [VAL_W-1:0] ay_q     [SLOTS];

	state_t            state_q, state_d;
	logic [SW-1:0]     slot_q;
	logic [7:0]        mask_q, last_q, buttons_q;
	logic              out_valid_q;
	logic [DIFF_W-1:0] diff_q;
	logic              right_q;

	logic [ALU_W-1:0] op_a, op_b;
	alu_res_t         res;
	logic             accept, is_report, last_slot, slot_adv, out_load;
	logic [VAL_W-1:0] x_cur, y_cur, ax_cur, ay_cur;
	logic [ALU_W-1:0] thr_ext;

	tgm_sub_unit u_sub (
		.a   (op_a),
		.b   (op_b),
		.res (res)
	);

	assign ev.ready    = (state_q == ST_IDLE);
	assign accept      = ev.valid && ev.ready;
	assign is_report   = (ev.event_type == EV_TYPE_SYNC) && (ev.event_code == CODE_REPORT);
	assign last_slot   = (slot_q == SW'(SLOTS - 1));
	assign x_cur       = x_q[slot_q];
	assign y_cur       = y_q[slot_q];
	assign ax_cur      = ax_q[slot_q];
	assign ay_cur      = ay_q[slot_q];
	assign thr_ext     = {{(ALU_W-CFG_W){1'b0}}, thr_q};
	assign btn.valid   = out_valid_q;
	assign btn.buttons = buttons_q;

	function automatic logic [ALU_W-1:0] sx_val(input logic [VAL_W-1:0] v);
		return {{(ALU_W-VAL_W){v[VAL_W-1]}}, v};
	endfunction

	function automatic logic [ALU_W-1:0] zx_cfg(input logic [CFG_W-1:0] v);
		return {{(ALU_W-CFG_W){1'b0}}, v};
	endfunction

	always_comb begin
		op_a = '0;
		op_b = '0;
		case (state_q)
			ST_ROLE: begin
				op_a = sx_val(x_cur);
				op_b = zx_cfg(rocker_q);
			end
			ST_DX: begin
				op_a = sx_val(x_cur);
				op_b = sx_val(ax_cur);
			end
			ST_DXP, ST_DYP: begin
				op_a = {{(ALU_W-DIFF_W){diff_q[DIFF_W-1]}}, diff_q};
				op_b = thr_ext;
			end
			ST_DXN, ST_DYN: begin
				op_a = {{(ALU_W-DIFF_W){diff_q[DIFF_W-1]}}, diff_q};
				op_b = -thr_ext;
			end
			ST_DY: begin
				op_a = sx_val(y_cur);
				op_b = sx_val(ay_cur);
			end
			ST_BX: begin
				op_a = sx_val(x_cur);
				op_b = zx_cfg(column_q);
			end
			ST_BBOT: begin
				op_a = sx_val(y_cur);
				op_b = zx_cfg(bottom_q);
			end
			ST_BTOP: begin
				op_a = sx_val(y_cur);
				op_b = zx_cfg(top_q);
			end
			default: ;
		endcase
	end

	always_comb begin
		state_d  = state_q;
		slot_adv = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept && is_report) begin
					state_d = ST_ROLE;
				end
			end
			ST_ROLE: begin
				if (!active_q[slot_q]) begin
					slot_adv = 1'b1;
				end else begin
					case (role_q[slot_q])
						ROLE_UNASSIGNED: state_d = res.neg ? ST_DX : ST_BX;
						ROLE_JOYSTICK:   state_d = ST_DX;
						ROLE_BUTTON:     state_d = ST_BX;
						default:         slot_adv = 1'b1;
					endcase
				end
			end
			ST_DX:  state_d = ST_DXP;
			ST_DXP: state_d = ST_DXN;
			ST_DXN: state_d = ST_DY;
			ST_DY:  state_d = ST_DYP;
			ST_DYP: state_d = ST_DYN;
			ST_DYN: slot_adv = 1'b1;
			ST_BX:  state_d = ST_BBOT;
			ST_BBOT: begin
				if (res.pos) begin
					slot_adv = 1'b1;
				end else begin
					state_d = ST_BTOP;
				end
			end
			ST_BTOP: slot_adv = 1'b1;
			ST_DONE: begin
				if (mask_q == last_q) begin
					state_d = ST_IDLE;
				end else if (!out_valid_q || btn.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		if (slot_adv) begin
			state_d = last_slot ? ST_DONE : ST_ROLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			thr_q       <= RST_MOVE_THRESHOLD;
			rocker_q    <= RST_ROCKER_ZONE_X;
			bottom_q    <= RST_BOTTOM_ROW_Y;
			top_q       <= RST_TOP_ROW_Y;
			column_q    <= RST_COLUMN_SPLIT_X;
			sel_slot_q  <= '0;
			slot_q      <= '0;
			mask_q      <= '0;
			last_q      <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < SLOTS; i++) begin
				active_q[i] <= 1'b0;
				role_q[i]   <= ROLE_UNASSIGNED;
				x_q[i]      <= '0;
				y_q[i]      <= '0;
				ax_q[i]     <= '0;
				ay_q[i]     <= '0;
			end
		end else begin
			state_q <= state_d;

			if (cfg_we) begin
				case (cfg_index)
					CFG_MOVE_THRESHOLD: thr_q    <= cfg_wdata;
					CFG_ROCKER_ZONE_X:  rocker_q <= cfg_wdata;
					CFG_BOTTOM_ROW_Y:   bottom_q <= cfg_wdata;
					CFG_TOP_ROW_Y:      top_q    <= cfg_wdata;
					CFG_COLUMN_SPLIT_X: column_q <= cfg_wdata;
					default: ;
				endcase
			end

			if (accept && (ev.event_type == EV_TYPE_ABS)) begin
				case (ev.event_code)
					CODE_SLOT: begin
						if (!ev.event_value[VAL_W-1] &&
							(ev.event_value < VAL_W'(SLOTS))) begin
							sel_slot_q <= ev.event_value[SW-1:0];
						end
					end
					CODE_TRACK: begin
						active_q[sel_slot_q] <= (ev.event_value != TRACK_END);
						role_q[sel_slot_q]   <= ROLE_UNASSIGNED;
					end
					CODE_POS_X: x_q[sel_slot_q] <= ev.event_value;
					CODE_POS_Y: y_q[sel_slot_q] <= ev.event_value;
					default: ;
				endcase
			end

			case (state_q)
				ST_IDLE: begin
					if (accept && is_report) begin
						slot_q <= '0;
						mask_q <= '0;
					end
				end
				ST_ROLE: begin
					if (active_q[slot_q] && (role_q[slot_q] == ROLE_UNASSIGNED)) begin
						if (res.neg) begin
							role_q[slot_q] <= ROLE_JOYSTICK;
							ax_q[slot_q]   <= x_cur;
							ay_q[slot_q]   <= y_cur;
						end else begin
							role_q[slot_q] <= ROLE_BUTTON;
						end
					end
				end
				ST_DX, ST_DY: diff_q <= res.diff[DIFF_W-1:0];
				ST_DXP: if (res.pos) mask_q[BTN_RIGHT] <= 1'b1;
				ST_DXN: if (res.neg) mask_q[BTN_LEFT] <= 1'b1;
				ST_DYP: if (res.pos) mask_q[BTN_DOWN] <= 1'b1;
				ST_DYN: if (res.neg) mask_q[BTN_UP] <= 1'b1;
				ST_BX:  right_q <= res.pos;
				ST_BBOT: begin
					if (res.pos) begin
						if (right_q) mask_q[BTN_A] <= 1'b1;
						else mask_q[BTN_B] <= 1'b1;
					end
				end
				ST_BTOP: begin
					if (res.neg) begin
						if (right_q) mask_q[BTN_START] <= 1'b1;
						else mask_q[BTN_SELECT] <= 1'b1;
					end
				end
				default: ;
			endcase

			if (slot_adv && !last_slot) begin
				slot_q <= slot_q + 1'b1;
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
				buttons_q   <= mask_q;
				last_q      <= mask_q;
			end else if (btn.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_load_shows_mask: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (btn.valid && (btn.buttons == $past(mask_q)) &&
			(last_q == $past(mask_q))))
		else $error("loaded mask not presented");

	a_report_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_report) |=> (!ev.ready && (mask_q == '0) && (slot_q == '0)))
		else $error("sync report did not start a slot walk");

	a_no_repeat: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && mask_q == last_q) |=> (btn.valid == $past(btn.valid && !btn.ready)))
		else $error("unchanged mask produced an item");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(sel_slot_q) < SLOTS) && (32'(slot_q) < SLOTS))
		else $error("slot pointer out of range");

endmodule
